/* rtl/core/rcqm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcqm_pkg
// Shared types and constants of the RED and CoDel queue manager.
// ----------------------------------------------------------------------------
package rcqm_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF    = 16;
  localparam int AVG_W           = 22;
  localparam int PROB_W          = 16;
  localparam int TIME_W          = 32;
  localparam int CNT_W           = 6;
  localparam int ST_W            = 3;
  localparam int OTAG_W          = 16;

  localparam logic [ST_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_FORCED   = 3'd2;
  localparam logic [ST_W-1:0] ST_RANDOM   = 3'd3;
  localparam logic [ST_W-1:0] ST_DELIVER  = 3'd4;
  localparam logic [ST_W-1:0] ST_DELAY    = 3'd5;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd6;

  localparam logic [2:0] REG_CAPACITY  = 3'd0;
  localparam logic [2:0] REG_WEIGHT    = 3'd1;
  localparam logic [2:0] REG_LOW       = 3'd2;
  localparam logic [2:0] REG_HIGH      = 3'd3;
  localparam logic [2:0] REG_PROB      = 3'd4;
  localparam logic [2:0] REG_PROB_DEG  = 3'd5;
  localparam logic [2:0] REG_TARGET    = 3'd6;
  localparam logic [2:0] REG_INTERVAL  = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0]  capacity;
    logic [15:0]       avg_weight;
    logic [AVG_W-1:0]  low_threshold;
    logic [AVG_W-1:0]  high_threshold;
    logic [PROB_W-1:0] drop_prob_max;
    logic [PROB_W-1:0] drop_prob_max_degraded;
    logic [TIME_W-1:0] target_delay;
    logic [TIME_W-1:0] drop_interval;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input item
    logic enq_eval;  // full check and average multiply
    logic avg_sum;   // finish average, decide forced and divide start
    logic div_step;  // one quotient bit
    logic enq_fin;   // decide random drop, push and emit
    logic deq_read;  // read head entry
    logic deq_fin;   // pop, classify and emit
  } cmd_t;

  typedef struct packed {
    logic is_deq;
    logic full;
    logic need_div;
    logic div_done;
    logic empty;
    logic deq_last;
  } stat_t;

endpackage

/* rtl/core/rcqm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcqm_ctrl
// Sequencer of the queue manager: steps enqueue and dequeue work.
// ----------------------------------------------------------------------------
module rcqm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire rcqm_pkg::stat_t st,
  output logic                busy,
  output rcqm_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_FIN   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_POP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.is_deq) begin
          state_nxt = st.empty ? S_POP : S_READ;
        end else begin
          cmd.enq_eval = 1'b1;
          state_nxt = st.full ? S_FIN : S_SUM;
        end
      end
      S_SUM: begin
        cmd.avg_sum = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (st.need_div && !st.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.enq_fin = 1'b1;
        state_nxt = S_IDLE;
      end
      S_READ: begin
        cmd.deq_read = 1'b1;
        state_nxt = S_POP;
      end
      S_POP: begin
        cmd.deq_fin = 1'b1;
        if (st.deq_last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = st.empty ? S_POP : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/rcqm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcqm_dp
// Datapath: packet store, occupancy average, drop divider and delay tracker.
// ----------------------------------------------------------------------------
module rcqm_dp #(
  parameter int QUEUE_DEPTH = rcqm_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = rcqm_pkg::TAG_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rcqm_pkg::cfg_t              cfg,
  input  wire rcqm_pkg::cmd_t              cmd,
  output rcqm_pkg::stat_t                  st,
  input  wire logic                        in_cmd,
  input  wire logic [rcqm_pkg::TIME_W-1:0] in_now_time,
  input  wire logic [TAG_BITS-1:0]         in_packet_tag,
  input  wire logic                        in_degraded,
  input  wire logic [15:0]                 in_random_value,
  output logic                             out_valid,
  output logic [rcqm_pkg::ST_W-1:0]        out_status,
  output logic [rcqm_pkg::OTAG_W-1:0]      out_tag,
  output logic [rcqm_pkg::TIME_W-1:0]      out_sojourn,
  output logic [rcqm_pkg::CNT_W-1:0]       out_occupancy,
  output logic                             out_last
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int AW    = rcqm_pkg::AVG_W;
  localparam int TW    = rcqm_pkg::TIME_W;
  localparam int CW    = rcqm_pkg::CNT_W;
  localparam int NUM_W = rcqm_pkg::PROB_W + AW;
  localparam int QB_W  = $clog2(NUM_W + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  logic [TAG_BITS-1:0] tag_mem [QUEUE_DEPTH];
  logic [TW-1:0]       stamp_mem [QUEUE_DEPTH];

  logic                 is_deq_r;
  logic [TW-1:0]        now_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic                 deg_r;
  logic [15:0]          rnd_r;
  logic [IDX_W-1:0]     head_r, tail_r;
  logic [CW-1:0]        count_r;
  logic [AW-1:0]        avg_r;
  logic                 above_r;
  logic [TW-1:0]        first_r;
  logic                 full_r;
  logic [AW+16:0]       prod_a_r;
  logic [AW+16:0]       prod_b_r;
  logic                 forced_r, need_div_r;
  logic [NUM_W-1:0]     num_r, quo_r;
  logic [AW:0]          rem_r;
  logic [AW-1:0]        den_r;
  logic [QB_W-1:0]      qbit_r;
  logic [TAG_BITS-1:0]  rd_tag_r;
  logic [TW-1:0]        rd_stamp_r;

  logic [CW-1:0]  cap_eff;
  logic [16:0]    w_inv;
  logic [AW+17:0] sum_w;
  logic [AW-1:0]  avg_new;
  logic [AW-1:0]  act_high;
  logic [15:0]    act_p;
  logic [AW+1:0]  high3;
  logic [AW:0]    rem_sh;
  logic [TW-1:0]  soj;
  logic           excess, drop_now;

  assign cap_eff  = (cfg.capacity > DEPTH_C) ? DEPTH_C : cfg.capacity;
  assign w_inv    = 17'h10000 - {1'b0, cfg.avg_weight};
  assign high3    = {2'b00, cfg.high_threshold} + {1'b0, cfg.high_threshold, 1'b0};
  assign act_high = deg_r ? high3[AW+1:2] : cfg.high_threshold;
  assign act_p    = deg_r ? cfg.drop_prob_max_degraded : cfg.drop_prob_max;
  assign sum_w    = {1'b0, prod_a_r} + {1'b0, prod_b_r};
  assign avg_new  = (|sum_w[AW+17:AW+16]) ? {AW{1'b1}} : sum_w[AW+15:16];
  assign rem_sh   = {rem_r[AW-1:0], num_r[NUM_W-1]};
  assign soj      = now_r - rd_stamp_r;
  assign excess   = soj > cfg.target_delay;
  assign drop_now = excess && above_r && ((now_r - first_r) > cfg.drop_interval);

  always_comb begin
    st.is_deq   = is_deq_r;
    st.full     = (count_r >= cap_eff);
    st.need_div = need_div_r;
    st.div_done = (qbit_r == '0);
    st.empty    = (count_r == '0);
    st.deq_last = (count_r == '0) || !drop_now;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_deq_r <= in_cmd;
      now_r    <= in_now_time;
      tag_r    <= in_packet_tag;
      deg_r    <= in_degraded;
      rnd_r    <= in_random_value;
    end
    if (cmd.enq_eval) begin
      full_r   <= (count_r >= cap_eff);
      prod_a_r <= {{AW{1'b0}}, w_inv} * {17'h0, avg_r};
      prod_b_r <= {{AW{1'b0}}, 1'b0, cfg.avg_weight} * {17'h0, count_r, 16'h0};
    end
    if (cmd.avg_sum) begin
      forced_r   <= avg_new > act_high;
      need_div_r <= (avg_new <= act_high) && (avg_new > cfg.low_threshold)
                    && (act_high > cfg.low_threshold);
      num_r      <= {{AW{1'b0}}, act_p} * {16'h0, avg_new - cfg.low_threshold};
      den_r      <= act_high - cfg.low_threshold;
      rem_r      <= '0;
      quo_r      <= '0;
      qbit_r     <= QB_W'(NUM_W);
    end
    if (cmd.div_step) begin
      num_r  <= {num_r[NUM_W-2:0], 1'b0};
      qbit_r <= qbit_r - 1'b1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_r <= rem_sh - {1'b0, den_r};
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.enq_fin && !full_r && !forced_r
        && !(need_div_r && ({16'h0, rnd_r} < quo_r))) begin
      tag_mem[tail_r]   <= tag_r;
      stamp_mem[tail_r] <= now_r;
    end
    if (cmd.deq_read) begin
      rd_tag_r   <= tag_mem[head_r];
      rd_stamp_r <= stamp_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      avg_r     <= '0;
      above_r   <= 1'b0;
      first_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.enq_fin || cmd.deq_fin;
      if (cmd.avg_sum) begin
        avg_r <= avg_new;
      end
      if (cmd.enq_fin) begin
        out_last      <= 1'b1;
        out_sojourn   <= '0;
        out_tag       <= rcqm_pkg::OTAG_W'(tag_r);
        if (full_r) begin
          out_status    <= rcqm_pkg::ST_FULL;
          out_occupancy <= count_r;
        end else if (forced_r) begin
          out_status    <= rcqm_pkg::ST_FORCED;
          out_occupancy <= count_r;
        end else if (need_div_r && ({16'h0, rnd_r} < quo_r)) begin
          out_status    <= rcqm_pkg::ST_RANDOM;
          out_occupancy <= count_r;
        end else begin
          out_status    <= rcqm_pkg::ST_ACCEPTED;
          tail_r        <= (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
          count_r       <= count_r + 1'b1;
          out_occupancy <= count_r + 1'b1;
        end
      end
      if (cmd.deq_fin) begin
        if (count_r == '0) begin
          out_status    <= rcqm_pkg::ST_EMPTY;
          out_tag       <= '0;
          out_sojourn   <= '0;
          out_occupancy <= '0;
          out_last      <= 1'b1;
        end else begin
          head_r        <= (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
          count_r       <= count_r - 1'b1;
          out_occupancy <= count_r - 1'b1;
          out_tag       <= rcqm_pkg::OTAG_W'(rd_tag_r);
          out_sojourn   <= soj;
          out_status    <= drop_now ? rcqm_pkg::ST_DELAY : rcqm_pkg::ST_DELIVER;
          out_last      <= !drop_now;
          if (!excess) begin
            above_r <= 1'b0;
          end else if (!above_r) begin
            above_r <= 1'b1;
            first_r <= now_r;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/red_codel_queue_manager_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// red_codel_queue_manager_core
// Packet queue with RED admission on enqueue and delay-based drop on dequeue.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// input     start high, busy low    in_cmd, in_now_time, in_packet_tag, ...
// result    out_valid strobe        out_status, out_tag, out_sojourn, ...
// config    APB write access phase  paddr, pwdata (prdata on reads)
//
// An enqueue steps through the capture, evaluation, average sum, divide and finish
// states, and a full drop skips the sum and divide; when the drop probability is
// computed, the restoring divider yields one quotient bit per cycle.
// A dequeue reads the head entry and then pops it; each further popped packet
// passes again through the registered store read, and an empty queue skips the
// read.
// Reset is synchronous; the store contents are not cleared.
// Each result is a one-cycle strobe and the receiver cannot stall it.
module red_codel_queue_manager_core #(
  parameter int QUEUE_DEPTH = rcqm_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = rcqm_pkg::TAG_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_cmd,
  input  wire logic [rcqm_pkg::TIME_W-1:0] in_now_time,
  input  wire logic [TAG_BITS-1:0]         in_packet_tag,
  input  wire logic                        in_degraded,
  input  wire logic [15:0]                 in_random_value,
  output logic                             out_valid,
  output logic [rcqm_pkg::ST_W-1:0]        out_status,
  output logic [rcqm_pkg::OTAG_W-1:0]      out_tag,
  output logic [rcqm_pkg::TIME_W-1:0]      out_sojourn,
  output logic [rcqm_pkg::CNT_W-1:0]       out_occupancy,
  output logic                             out_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [4:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  rcqm_pkg::cfg_t  cfg_r;
  rcqm_pkg::cmd_t  cmd;
  rcqm_pkg::stat_t st;
  logic [2:0]      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity               <= 6'd32;
      cfg_r.avg_weight             <= 16'd131;
      cfg_r.low_threshold          <= 22'd419430;
      cfg_r.high_threshold         <= 22'd1677722;
      cfg_r.drop_prob_max          <= 16'd6554;
      cfg_r.drop_prob_max_degraded <= 16'd19661;
      cfg_r.target_delay           <= 32'd5000;
      cfg_r.drop_interval          <= 32'd100000;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        rcqm_pkg::REG_CAPACITY: cfg_r.capacity <= pwdata[5:0];
        rcqm_pkg::REG_WEIGHT:   cfg_r.avg_weight <= pwdata[15:0];
        rcqm_pkg::REG_LOW:      cfg_r.low_threshold <= pwdata[21:0];
        rcqm_pkg::REG_HIGH:     cfg_r.high_threshold <= pwdata[21:0];
        rcqm_pkg::REG_PROB:     cfg_r.drop_prob_max <= pwdata[15:0];
        rcqm_pkg::REG_PROB_DEG: cfg_r.drop_prob_max_degraded <= pwdata[15:0];
        rcqm_pkg::REG_TARGET:   cfg_r.target_delay <= pwdata;
        rcqm_pkg::REG_INTERVAL: cfg_r.drop_interval <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcqm_pkg::REG_CAPACITY: prdata = {26'h0, cfg_r.capacity};
      rcqm_pkg::REG_WEIGHT:   prdata = {16'h0, cfg_r.avg_weight};
      rcqm_pkg::REG_LOW:      prdata = {10'h0, cfg_r.low_threshold};
      rcqm_pkg::REG_HIGH:     prdata = {10'h0, cfg_r.high_threshold};
      rcqm_pkg::REG_PROB:     prdata = {16'h0, cfg_r.drop_prob_max};
      rcqm_pkg::REG_PROB_DEG: prdata = {16'h0, cfg_r.drop_prob_max_degraded};
      rcqm_pkg::REG_TARGET:   prdata = cfg_r.target_delay;
      rcqm_pkg::REG_INTERVAL: prdata = cfg_r.drop_interval;
      default:                prdata = '0;
    endcase
  end

  rcqm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  rcqm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .cmd             (cmd),
    .st              (st),
    .in_cmd          (in_cmd),
    .in_now_time     (in_now_time),
    .in_packet_tag   (in_packet_tag),
    .in_degraded     (in_degraded),
    .in_random_value (in_random_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_tag         (out_tag),
    .out_sojourn     (out_sojourn),
    .out_occupancy   (out_occupancy),
    .out_last        (out_last)
  );

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid)
    else $error("result transfer while idle");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("busy after final transfer");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= rcqm_pkg::CNT_W'(QUEUE_DEPTH)))
    else $error("occupancy beyond depth");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rcqm_pkg::ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty result with packets held");

endmodule
`default_nettype wire
